// File: sv/ppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types for the prefix period detector: input and result transactions,
// the item passed from front to back, and the back-end state encoding.
// ----------------------------------------------------------------------------
package ppd_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       start_new;
  } ppd_in_t;

  typedef struct packed {
    logic [10:0] prefix_length;
    logic [9:0]  border_length;
    logic        periodic;
    logic [10:0] repeat_count;
    logic        overflow;
  } ppd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDP,
    ST_CMP,
    ST_RDB,
    ST_DIV,
    ST_OUT
  } ppd_state_e;

endpackage

// File: sv/ppd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/ppd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_front
// Input side: a two-entry queue that takes transactions and hands them to the
// back end, so the input keeps accepting while the back end works and an entry is free.
// ----------------------------------------------------------------------------
module ppd_front import ppd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  ppd_in_t in_data_i,
  output logic    q_valid_o,
  input  logic    q_ready_i,
  output ppd_in_t q_data_o
);

  ppd_in_t    buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = buf_q[rptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= in_data_i;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: sv/ppd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_back
// Border walk over the pattern and border memories, then a restoring divide
// for the repeat count, then the result register.
// ----------------------------------------------------------------------------
module ppd_back import ppd_pkg::*; #(
  parameter int MaxLen = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  output logic     q_ready_o,
  input  ppd_in_t  q_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ppd_out_t out_data_o
);

  localparam int PW = $clog2(MaxLen + 1);   // position width
  localparam int AW = $clog2(MaxLen);       // pattern address width
  localparam int BW = $clog2(MaxLen + 2);   // border entry: value plus one
  localparam int CW = $clog2(PW + 1);       // divide step counter width

  ppd_state_e state_q, state_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW:0]   walk_q, walk_d;   // border of current prefix plus one
  logic [PW:0]   j_q, j_d;         // walk index plus one (0 = minus one)
  logic [7:0]    ch_q, ch_d;
  logic [PW-1:0] len_q, len_d;
  logic [PW-1:0] brd_q, brd_d;
  logic [PW-1:0] rem_q, rem_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [PW-1:0] dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  ppd_out_t      res_q, res_d;
  logic          res_v_q, res_v_d;

  logic          p_we, b_we;
  logic [AW-1:0] p_ra, p_wa;
  logic [PW-1:0] b_ra, b_wa;
  logic [BW-1:0] b_wd, b_rd;
  logic [7:0]    p_rd;
  logic [PW-1:0] cur_pos;
  logic [PW:0]   rem_sh;

  ppd_ram #(.Width(8), .Depth(MaxLen)) u_pat (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(ch_q),
    .raddr_i(p_ra), .rdata_o(p_rd)
  );

  ppd_ram #(.Width(BW), .Depth(MaxLen + 1)) u_brd (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(b_wd),
    .raddr_i(b_ra), .rdata_o(b_rd)
  );

  assign cur_pos   = q_data_i.start_new ? '0 : pos_q;
  assign q_ready_o = (state_q == ST_IDLE) && !res_v_q;
  assign out_valid_o = res_v_q;
  assign out_data_o  = res_q;
  assign rem_sh = {rem_q, quo_q[PW-1]};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (q_valid_i && q_ready_o) state_d = ST_CMP;
      ST_RDP:  state_d = ST_CMP;
      ST_CMP:  begin
        if (ovf_q || j_q == '0 || j_q > {1'b0, pos_q} || p_rd == ch_q) state_d = ST_DIV;
        else state_d = ST_RDB;
      end
      ST_RDB:  state_d = ST_RDP;
      ST_DIV:  if (ovf_q || cnt_q == '0) state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pos_d = pos_q; walk_d = walk_q; j_d = j_q; ch_d = ch_q; len_d = len_q;
    brd_d = brd_q; rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    ovf_d = ovf_q; res_d = res_q; res_v_d = res_v_q;
    p_we = 1'b0; p_wa = pos_q[AW-1:0];
    b_we = 1'b0; b_wa = pos_q; b_wd = '0; b_ra = j_q[PW-1:0];
    p_ra = j_q[AW-1:0] - 1'b1;
    if (out_valid_o && out_ready_i) res_v_d = 1'b0;
    unique case (state_q)
      ST_IDLE: if (q_valid_i && q_ready_o) begin
        ch_d  = q_data_i.char_in;
        pos_d = cur_pos;
        walk_d = q_data_i.start_new ? '0 : walk_q;
        j_d   = q_data_i.start_new ? '0 : walk_q;
        ovf_d = (cur_pos == PW'(MaxLen));
        // prefetch pattern entry at walk index
        p_ra  = walk_q[AW-1:0] - 1'b1;
        if (q_data_i.start_new) j_d = '0;
      end
      ST_RDP: ;
      ST_CMP: begin
        if (ovf_q) begin
          cnt_d = '0;
        end else if (j_q == '0 || j_q > {1'b0, pos_q} || p_rd == ch_q) begin
          // walk done: border is j (j_q minus one), plus one
          len_d = pos_q + 1'b1;
          brd_d = (j_q == '0 || j_q > {1'b0, pos_q}) ? '0 : j_q[PW-1:0];
          p_we  = 1'b1;
          b_we  = 1'b1;
          b_wa  = pos_q + 1'b1;
          b_wd  = BW'(((j_q == '0 || j_q > {1'b0, pos_q}) ? '0 : j_q[PW-1:0]) + 1'b1);
          pos_d = pos_q + 1'b1;
          walk_d = {1'b0, ((j_q == '0 || j_q > {1'b0, pos_q}) ? '0 : j_q[PW-1:0])} + 1'b1;
          dvs_d = pos_q + 1'b1 - ((j_q == '0 || j_q > {1'b0, pos_q}) ? '0 : j_q[PW-1:0]);
          quo_d = pos_q + 1'b1;
          rem_d = '0;
          cnt_d = CW'(PW);
        end else begin
          b_ra = j_q[PW-1:0] - 1'b1;
        end
      end
      ST_RDB: begin
        // entry zero is never written, so the walk ends when it would read it
        j_d  = (j_q == (PW+1)'(1)) ? '0 : {1'b0, b_rd[PW-1:0]};
        p_ra = b_rd[AW-1:0] - 1'b1;
      end
      ST_DIV: if (!ovf_q && cnt_q != '0) begin
        // one restoring divide step per cycle
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_d = rem_sh[PW-1:0] - dvs_q;
          quo_d = {quo_q[PW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[PW-1:0];
          quo_d = {quo_q[PW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
      end
      ST_OUT: begin
        res_v_d = 1'b1;
        res_d.overflow = ovf_q;
        if (ovf_q) begin
          res_d.prefix_length = 11'(MaxLen);
          res_d.border_length = '0;
          res_d.periodic = 1'b0;
          res_d.repeat_count = '0;
        end else begin
          res_d.prefix_length = 11'(len_q);
          res_d.border_length = 10'(brd_q);
          res_d.periodic = (len_q >= PW'(2)) && (brd_q != '0) && (rem_q == '0);
          res_d.repeat_count = ((len_q >= PW'(2)) && (brd_q != '0) && (rem_q == '0))
                               ? 11'(quo_q) : '0;
        end
      end
      default: ;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      walk_q  <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      walk_q  <= walk_d;
      res_v_q <= res_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    j_q <= j_d; ch_q <= ch_d; len_q <= len_d; brd_q <= brd_d; rem_q <= rem_d;
    quo_q <= quo_d; dvs_q <= dvs_d; cnt_q <= cnt_d; ovf_q <= ovf_d; res_q <= res_d;
  end

endmodule

// File: sv/prefix_period_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_period_detector
// Incremental border table of a byte string with period detection.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | ppd_in_t
//   out     | output    | out_valid/out_ready| ppd_out_t
//
// For a stored byte the back end compares, walks the border chain (amortized
// under two steps per byte), then runs the restoring divider, one step per
// position bit (11 by default), and registers the result.
// A dropped byte (store full) skips the walk and divide and flags overflow.
// The back end takes the next byte only once the result is gone, so it never
// takes a new byte while the last one is in work or its result is waiting.
// Reset clears position and walk state; the memories need no clearing.
// A two-entry input queue accepts while back end or output stall, until full.
// ----------------------------------------------------------------------------
module prefix_period_detector import ppd_pkg::*; #(
  parameter int MaxLen = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ppd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ppd_out_t out_data_o
);

  logic    q_valid, q_ready;
  ppd_in_t q_data;

  ppd_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  ppd_back #(.MaxLen(MaxLen)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
